// ===== src/ppu_pkg.sv =====
// Shared types, constants and a helper function of the particle pool.
package ppu_pkg;

	localparam int MAX_PARTICLES = 64;
	localparam int DEN_W = 10;
	localparam int Q_W = 16;
	localparam int LANES = 5;

	typedef struct packed {
		logic        mode;
		logic [9:0]  life;
		logic [47:0] position;
		logic [47:0] velocity;
		logic [47:0] acceleration;
		logic [15:0] birth_scale;
		logic [15:0] death_scale;
		logic [31:0] birth_rgba;
		logic [31:0] death_rgba;
	} ppu_in_t;

	typedef struct packed {
		logic [47:0] particle_position;
		logic [15:0] particle_scale;
		logic [31:0] particle_color;
		logic        last;
	} ppu_out_t;

	typedef struct packed {
		logic [47:0] position;
		logic [47:0] velocity;
		logic [47:0] acceleration;
		logic [9:0]  life;
		logic [9:0]  age;
		logic [31:0] scale_pair;
		logic [31:0] birth_rgba;
		logic [31:0] death_rgba;
	} ppu_entry_t;

	typedef struct packed {
		logic load;
		logic step;
	} ppu_div_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DIV,
		ST_EMIT
	} ppu_state_t;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// Component-wise saturating add of two packed signed Q8.8 vectors.
	function automatic logic [47:0] vec_add_sat(input logic [47:0] a, input logic [47:0] b);
		logic [47:0] r;
		logic signed [16:0] s;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			s = 17'(signed'(a[16*k +: 16])) + 17'(signed'(b[16*k +: 16]));
			if (s > 17'sd32767) r[16*k +: 16] = 16'h7fff;
			else if (s < -17'sd32768) r[16*k +: 16] = 16'h8000;
			else r[16*k +: 16] = s[15:0];
		end
		return r;
	endfunction

endpackage

// ===== src/particle_pool_update.sv =====
// Particle pool top level: sequencer, pool addressing and result output.
//
// An add transaction leaves busy low; it is dropped when the pool is full.
// A tick holds busy high while it walks the pool: each particle costs one memory read and a
// check, and each survivor a pass through the bit-serial divider (a load and 16 steps) and
// one write-back. The final result of a tick appears in the first cycle with busy low again.
// Results leave on strobe for one cycle each and cannot be held off by the receiver.
module particle_pool_update #(
	parameter int MAX_PARTICLES = ppu_pkg::MAX_PARTICLES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ppu_pkg::ppu_in_t  request,
	output logic              strobe,
	output ppu_pkg::ppu_out_t result
);

	localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int DW = ppu_pkg::DEN_W;
	localparam int QW = ppu_pkg::Q_W;
	localparam int NW = DW + QW;
	localparam int NL = ppu_pkg::LANES;

	ppu_pkg::ppu_state_t state_q, state_d;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q, i_q, n_q;
	logic [4:0]    step_q;
	logic          pend_q;
	ppu_pkg::ppu_out_t pend_res_q;
	ppu_pkg::ppu_entry_t ent_q, rd_data, wdata;
	logic [NL-1:0] neg_q;
	logic [NW-1:0] num_q [NL];
	logic [QW-1:0] quo [NL];

	logic          we;
	logic [AW-1:0] waddr, raddr, head_dec;
	logic          add_ok, expired;
	ppu_pkg::ppu_div_ctl_t div_ctl;
	ppu_pkg::ppu_out_t new_res, fin_res;
	ppu_pkg::ppu_entry_t upd;
	logic [9:0]    age1;
	logic [47:0]   new_vel;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [AW+CW:0] s;
		s = (AW+CW+1)'(base) + (AW+CW+1)'(off);
		if (s >= (AW+CW+1)'(MAX_PARTICLES)) s = s - (AW+CW+1)'(MAX_PARTICLES);
		return s[AW-1:0];
	endfunction

	ppu_mem #(.DEPTH(MAX_PARTICLES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	for (genvar g = 0; g < NL; g++) begin : g_lane
		ppu_div #(.DEN_W(DW), .Q_W(QW)) u_div (
			.clk (clk),
			.ctl (div_ctl),
			.num (num_q[g]),
			.den (ent_q.life),
			.quo (quo[g])
		);
	end

	assign busy = state_q != ppu_pkg::ST_IDLE;
	assign head_dec = (head_q == '0) ? AW'(MAX_PARTICLES - 1) : AW'(head_q - 1'b1);
	assign add_ok = state_q == ppu_pkg::ST_IDLE && start && request.mode == ppu_pkg::MODE_ADD
		&& count_q < CW'(MAX_PARTICLES);
	assign raddr = wrap_add(head_q, i_q);
	assign expired = rd_data.age >= rd_data.life;
	assign age1 = 10'(rd_data.age + 1'b1);
	assign new_vel = ppu_pkg::vec_add_sat(rd_data.velocity, rd_data.acceleration);

	always_comb begin
		we = 1'b0;
		waddr = head_dec;
		wdata = ent_q;
		if (add_ok) begin
			we = 1'b1;
			wdata.position = request.position;
			wdata.velocity = request.velocity;
			wdata.acceleration = request.acceleration;
			wdata.life = request.life;
			wdata.age = '0;
			wdata.scale_pair = {request.death_scale, request.birth_scale};
			wdata.birth_rgba = request.birth_rgba;
			wdata.death_rgba = request.death_rgba;
		end else if (state_q == ppu_pkg::ST_EMIT) begin
			we = 1'b1;
			waddr = wrap_add(head_q, n_q);
		end
	end

	always_comb begin
		new_res.particle_position = ent_q.position;
		new_res.particle_scale = neg_q[0] ? 16'(ent_q.scale_pair[15:0] - quo[0])
			: 16'(ent_q.scale_pair[15:0] + quo[0]);
		for (int c = 0; c < 4; c++) begin
			new_res.particle_color[8*c +: 8] = neg_q[c+1]
				? 8'(ent_q.birth_rgba[8*c +: 8] - quo[c+1][7:0])
				: 8'(ent_q.birth_rgba[8*c +: 8] + quo[c+1][7:0]);
		end
		new_res.last = 1'b0;
	end

	always_comb begin
		fin_res = pend_res_q;
		fin_res.last = state_q == ppu_pkg::ST_READ;
		upd = rd_data;
		upd.age = age1;
		upd.velocity = new_vel;
		upd.position = ppu_pkg::vec_add_sat(rd_data.position, new_vel);
	end

	always_comb begin
		state_d = state_q;
		div_ctl = '0;
		case (state_q)
			ppu_pkg::ST_IDLE: begin
				if (start && request.mode == ppu_pkg::MODE_TICK) state_d = ppu_pkg::ST_READ;
			end
			ppu_pkg::ST_READ: begin
				state_d = (i_q == count_q) ? ppu_pkg::ST_IDLE : ppu_pkg::ST_CHECK;
			end
			ppu_pkg::ST_CHECK: begin
				if (expired) begin
					state_d = ppu_pkg::ST_READ;
				end else begin
					state_d = ppu_pkg::ST_DIV;
				end
			end
			ppu_pkg::ST_DIV: begin
				// The numerators are registered in the check state, so the lanes load in the cycle after it.
				if (step_q == '0) div_ctl.load = 1'b1;
				else div_ctl.step = 1'b1;
				if (step_q == 5'(QW)) state_d = ppu_pkg::ST_EMIT;
			end
			ppu_pkg::ST_EMIT: begin
				state_d = ppu_pkg::ST_READ;
			end
			default: state_d = ppu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppu_pkg::ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			i_q <= '0;
			n_q <= '0;
			step_q <= '0;
			pend_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe <= 1'b0;
			case (state_q)
				ppu_pkg::ST_IDLE: begin
					if (add_ok) begin
						head_q <= head_dec;
						count_q <= CW'(count_q + 1'b1);
					end
					i_q <= '0;
					n_q <= '0;
					pend_q <= 1'b0;
				end
				ppu_pkg::ST_READ: begin
					if (i_q == count_q) begin
						count_q <= n_q;
						// The held result is the final survivor of this tick.
						if (pend_q) begin
							strobe <= 1'b1;
						end
						pend_q <= 1'b0;
					end
				end
				ppu_pkg::ST_CHECK: begin
					i_q <= CW'(i_q + 1'b1);
					step_q <= '0;
				end
				ppu_pkg::ST_DIV: begin
					step_q <= 5'(step_q + 1'b1);
				end
				ppu_pkg::ST_EMIT: begin
					n_q <= CW'(n_q + 1'b1);
					pend_q <= 1'b1;
					if (pend_q) begin
						strobe <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers. A result is held back until it is known whether another follows.
	always_ff @(posedge clk) begin
		if (state_q == ppu_pkg::ST_READ && i_q == count_q) begin
			result <= fin_res;
		end else if (state_q == ppu_pkg::ST_EMIT) begin
			result <= fin_res;
			pend_res_q <= new_res;
		end
		if (state_q == ppu_pkg::ST_CHECK) begin
			ent_q <= upd;
			neg_q[0] <= rd_data.scale_pair[31:16] < rd_data.scale_pair[15:0];
			num_q[0] <= NW'((rd_data.scale_pair[31:16] < rd_data.scale_pair[15:0]
				? 16'(rd_data.scale_pair[15:0] - rd_data.scale_pair[31:16])
				: 16'(rd_data.scale_pair[31:16] - rd_data.scale_pair[15:0])) * age1);
			for (int c = 0; c < 4; c++) begin
				neg_q[c+1] <= rd_data.death_rgba[8*c +: 8] < rd_data.birth_rgba[8*c +: 8];
				num_q[c+1] <= NW'((rd_data.death_rgba[8*c +: 8] < rd_data.birth_rgba[8*c +: 8]
					? 8'(rd_data.birth_rgba[8*c +: 8] - rd_data.death_rgba[8*c +: 8])
					: 8'(rd_data.death_rgba[8*c +: 8] - rd_data.birth_rgba[8*c +: 8])) * age1);
			end
		end
	end

endmodule

// ===== src/ppu_mem.sv =====
// Particle pool storage: one write port and one registered read port.
module ppu_mem #(
	parameter int DEPTH = ppu_pkg::MAX_PARTICLES,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  ppu_pkg::ppu_entry_t  wdata,
	input  logic [AW-1:0]        raddr,
	output ppu_pkg::ppu_entry_t  rdata
);

	ppu_pkg::ppu_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/ppu_div.sv =====
// One lane of the shared restoring divider, one quotient bit per step.
module ppu_div #(
	parameter int DEN_W = ppu_pkg::DEN_W,
	parameter int Q_W = ppu_pkg::Q_W
) (
	input  logic                     clk,
	input  ppu_pkg::ppu_div_ctl_t    ctl,
	input  logic [DEN_W+Q_W-1:0]     num,
	input  logic [DEN_W-1:0]         den,
	output logic [Q_W-1:0]           quo
);

	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0]   low_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, low_q[Q_W-1]};
	assign ge = trial >= {1'b0, den};
	assign quo = low_q;

	// The quotient is known to fit Q_W bits, so the upper numerator bits start as remainder.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= num[DEN_W+Q_W-1:Q_W];
			low_q <= num[Q_W-1:0];
		end else if (ctl.step) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			low_q <= {low_q[Q_W-2:0], ge};
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the particle pool: random adds and ticks against a pool predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_SIZE = 64;
	localparam int CYCLE_LIMIT = 1000000;

	class pool_scoreboard;
		ppu_pkg::ppu_entry_t pool[$];
		ppu_pkg::ppu_out_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
			logic [47:0] r;
			int s;
			for (int k = 0; k < 3; k++) begin
				s = int'($signed(a[16*k +: 16])) + int'($signed(b[16*k +: 16]));
				if (s > 32767) s = 32767;
				if (s < -32768) s = -32768;
				r[16*k +: 16] = s[15:0];
			end
			return r;
		endfunction

		function int fade(int s, int e, int num, int den);
			return s + ((e - s) * num) / den;
		endfunction

		// Notes an accepted transaction and queues the particles a tick will emit.
		function void note_request(ppu_pkg::ppu_in_t req);
			ppu_pkg::ppu_entry_t p;
			ppu_pkg::ppu_entry_t kept[$];
			ppu_pkg::ppu_out_t o;
			if (req.mode == ppu_pkg::MODE_ADD) begin
				if (pool.size() >= POOL_SIZE) return;
				p.position = req.position;
				p.velocity = req.velocity;
				p.acceleration = req.acceleration;
				p.life = req.life;
				p.age = '0;
				p.scale_pair = {req.death_scale, req.birth_scale};
				p.birth_rgba = req.birth_rgba;
				p.death_rgba = req.death_rgba;
				pool.push_front(p);
				return;
			end
			foreach (pool[i]) if (pool[i].age < pool[i].life) kept.push_back(pool[i]);
			pool = kept;
			foreach (pool[i]) begin
				pool[i].age = pool[i].age + 1;
				pool[i].velocity = sat_add(pool[i].velocity, pool[i].acceleration);
				pool[i].position = sat_add(pool[i].position, pool[i].velocity);
				o.particle_position = pool[i].position;
				o.particle_scale = 16'(fade(pool[i].scale_pair[15:0], pool[i].scale_pair[31:16],
					pool[i].age, pool[i].life));
				for (int c = 0; c < 4; c++)
					o.particle_color[8*c +: 8] = 8'(fade(pool[i].birth_rgba[8*c +: 8],
						pool[i].death_rgba[8*c +: 8], pool[i].age, pool[i].life));
				o.last = (i == pool.size() - 1);
				pending.push_back(o);
			end
		endfunction

		function void check_result(ppu_pkg::ppu_out_t got);
			ppu_pkg::ppu_out_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.particle_position !== want.particle_position) begin
				$display("%0t: position expected %h actual %h", $time,
					want.particle_position, got.particle_position);
				errors++;
			end
			if (got.particle_scale !== want.particle_scale) begin
				$display("%0t: scale expected %h actual %h", $time,
					want.particle_scale, got.particle_scale);
				errors++;
			end
			if (got.particle_color !== want.particle_color) begin
				$display("%0t: colour expected %h actual %h", $time,
					want.particle_color, got.particle_color);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %b actual %b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic strobe;
	ppu_pkg::ppu_in_t request = '0;
	ppu_pkg::ppu_out_t result;
	pool_scoreboard board = new();
	int cycles = 0;
	bit steady = 1'b0;

	particle_pool_update dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .strobe(strobe), .result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) if (arst_n && strobe) board.check_result(result);

	function automatic logic [47:0] rand_vec(bit wild);
		logic [47:0] v;
		for (int k = 0; k < 3; k++)
			v[16*k +: 16] = wild ? 16'($urandom) : 16'($signed($urandom_range(0, 1536)) - 768);
		return v;
	endfunction

	// Drives one transaction and holds until the block takes it.
	task automatic send(ppu_pkg::ppu_in_t req);
		int gap;
		gap = 0;
		if (!steady) while ($urandom_range(0, 99) < 36) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		board.note_request(req);
	endtask

	task automatic add(logic [9:0] life, bit wild);
		ppu_pkg::ppu_in_t r;
		r.mode = ppu_pkg::MODE_ADD;
		r.life = life;
		r.position = rand_vec(wild);
		r.velocity = rand_vec(wild);
		r.acceleration = rand_vec(wild);
		r.birth_scale = 16'($urandom);
		r.death_scale = 16'($urandom);
		r.birth_rgba = $urandom;
		r.death_rgba = $urandom;
		send(r);
	endtask

	task automatic tick();
		ppu_pkg::ppu_in_t r;
		logic [255:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = noise[$bits(ppu_pkg::ppu_in_t)-1:0];
		r.mode = ppu_pkg::MODE_TICK;
		send(r);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		ppu_pkg::ppu_in_t r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tick, zero and extreme lifetimes, saturating extremes, full pool.
		tick();
		add(10'd0, 1'b0);
		tick();
		r = '0;
		r.mode = ppu_pkg::MODE_ADD;
		r.life = 10'd1023;
		r.position = 48'h7fff_8000_7fff;
		r.velocity = 48'h7fff_8000_7fff;
		r.acceleration = 48'h7fff_8000_7fff;
		r.birth_scale = 16'hffff;
		r.death_rgba = 32'hffff_ffff;
		send(r);
		r.life = 10'd1;
		r.position = 48'h8000_7fff_8000;
		r.velocity = 48'h8000_7fff_8000;
		r.acceleration = 48'h8000_7fff_8000;
		r.birth_scale = 16'h0;
		r.death_scale = 16'hffff;
		r.birth_rgba = 32'hffff_ffff;
		r.death_rgba = 32'h0;
		send(r);
		tick();
		tick();
		steady = 1'b1;
		repeat (66) add(10'($urandom_range(2, 40)), 1'b1);
		steady = 1'b0;
		tick();
		drain();

		for (int n = 0; n < 95; n++) begin
			if ($urandom_range(0, 99) < 35) tick();
			else add(($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 12)),
				$urandom_range(0, 3) == 0);
			if (n == 45) drain();
		end
		tick();
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
